[rtl/gmde_pkg.sv]
// Shared constants, cell classes and helper functions for the maze explorer.
`default_nettype none
package gmde_pkg;
   localparam int DefMaxRows = 64;
   localparam int DefMaxCols = 64;
   localparam int CntW = 13;
   localparam logic [CntW-1:0] CountMax = 13'd8191;

   localparam logic [2:0] ClsOther   = 3'd0;
   localparam logic [2:0] ClsWall    = 3'd1;
   localparam logic [2:0] ClsBlocked = 3'd2;
   localparam logic [2:0] ClsPrize   = 3'd3;
   localparam logic [2:0] ClsSpace   = 3'd4;
   localparam logic [2:0] ClsOrigin  = 3'd5;

   localparam logic [1:0] DirRight = 2'd0;
   localparam logic [1:0] DirLeft  = 2'd1;
   localparam logic [1:0] DirDown  = 2'd2;
   localparam logic [1:0] DirUp    = 2'd3;

   localparam logic [0:0] RegRows = 1'b0;
   localparam logic [0:0] RegCols = 1'b1;

   function automatic logic [2:0] classify(input logic [7:0] ch);
      logic [2:0] cls;
      unique case (ch)
         8'h78:   cls = ClsWall;
         8'h62:   cls = ClsBlocked;
         8'h70:   cls = ClsPrize;
         8'h20:   cls = ClsSpace;
         8'h6f:   cls = ClsOrigin;
         default: cls = ClsOther;
      endcase
      return cls;
   endfunction

   function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
      return (v < CountMax) ? v + 1'b1 : v;
   endfunction
endpackage
`default_nettype wire

[rtl/gmde_if.sv]
// Valid/ready channel interfaces for map cells and result totals.
`default_nettype none
interface gmde_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] cell_char;
   logic       last_cell;
   modport source (output valid, cell_char, last_cell, input ready);
   modport sink (input valid, cell_char, last_cell, output ready);
endinterface

interface gmde_rsp_if;
   logic        valid;
   logic        ready;
   logic        border_ok;
   logic        origin_found;
   logic [12:0] total_prizes;
   logic [12:0] total_open;
   logic [12:0] prizes_collected;
   logic [12:0] cells_entered;
   modport source (output valid, border_ok, origin_found, total_prizes, total_open,
                   prizes_collected, cells_entered, input ready);
   modport sink (input valid, border_ok, origin_found, total_prizes, total_open,
                 prizes_collected, cells_entered, output ready);
endinterface
`default_nettype wire

[rtl/grid_maze_depth_first_explorer_unit.sv]
// Maze explorer top level: cell load, border/origin scan, depth-first walk.
//  channel | dir | fields
//  req_    | in  | cell_char[7:0], last_cell
//  rsp_    | out | border_ok, origin_found, total_prizes, total_open,
//          |     | prizes_collected, cells_entered
//  csr_    | in  | csr_we, csr_index, csr_wdata[6:0]
// Cells load one per cycle into the map RAM, only while in the load state.
// After the last cell a scan reads every cell (address, then registered data).
// An init state starts the walk; an in-map probe reads its cell in a check
// state; a backtrack pops the stack, then reads it. Reset is synchronous.
// While a result waits on rsp_ready the block accepts no new cells.
`default_nettype none
module grid_maze_depth_first_explorer_unit
   import gmde_pkg::*;
#(
   parameter int MaxRows = DefMaxRows,
   parameter int MaxCols = DefMaxCols
) (
   input  wire logic       clock,
   input  wire logic       reset,
   gmde_req_if.sink        req,
   gmde_rsp_if.source      rsp,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_wdata
);
   localparam int RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
   localparam int ColW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
   localparam int AddrW = RowW + ColW;
   localparam int Depth = 1 << AddrW;
   localparam int SzW = 9;

   localparam logic [2:0] StLoad = 3'd0;
   localparam logic [2:0] StScan = 3'd1;
   localparam logic [2:0] StProbe = 3'd2;
   localparam logic [2:0] StCheck = 3'd3;
   localparam logic [2:0] StPop = 3'd4;
   localparam logic [2:0] StBack = 3'd5;
   localparam logic [2:0] StDone = 3'd6;
   localparam logic [2:0] StInit = 3'd7;

   logic [6:0] rows_ff, cols_ff;
   logic [SzW-1:0] rows_c, cols_c;
   logic [2:0] state_ff, state_in;
   logic [RowW-1:0] lrow_ff, lrow_in, rrow_ff, rrow_in, orow_ff, orow_in, srow_ff, srow_in;
   logic [ColW-1:0] lcol_ff, lcol_in, rcol_ff, rcol_in, ocol_ff, ocol_in, scol_ff, scol_in;
   logic [RowW-1:0] prow_ff, prow_in;
   logic [ColW-1:0] pcol_ff, pcol_in;
   logic [1:0] dir_ff, dir_in;
   logic scan_wait_ff, scan_wait_in;
   logic [AddrW:0] sp_ff, sp_in;
   logic border_ff, border_in, oseen_ff, oseen_in, walked_ff, walked_in;
   logic [CntW-1:0] ptot_ff, ptot_in, otot_ff, otot_in, pcnt_ff, pcnt_in, mcnt_ff, mcnt_in;

   logic map_we;
   logic [AddrW-1:0] map_waddr, map_raddr;
   logic [3:0] map_wdata, map_rdata;
   logic stk_we;
   logic [AddrW-1:0] stk_waddr, stk_raddr;
   logic [1:0] stk_wdata, stk_rdata;

   gmde_ram #(.Width(4), .Depth(Depth)) u_map (
      .clock, .wr_en(map_we), .wr_addr(map_waddr), .wr_data(map_wdata),
      .rd_addr(map_raddr), .rd_data(map_rdata));
   gmde_ram #(.Width(2), .Depth(Depth)) u_stack (
      .clock, .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata));

   always_comb begin
      rows_c = (rows_ff == 7'd0) ? SzW'(1) :
               (SzW'(rows_ff) > SzW'(MaxRows)) ? SzW'(MaxRows) : SzW'(rows_ff);
      cols_c = (cols_ff == 7'd0) ? SzW'(1) :
               (SzW'(cols_ff) > SzW'(MaxCols)) ? SzW'(MaxCols) : SzW'(cols_ff);
   end

   logic req_fire, rsp_fire;
   assign req.ready = (state_ff == StLoad);
   assign req_fire = req.valid && req.ready;
   assign rsp.valid = (state_ff == StDone);
   assign rsp_fire = rsp.valid && rsp.ready;
   assign rsp.border_ok = border_ff;
   assign rsp.origin_found = oseen_ff;
   assign rsp.total_prizes = ptot_ff;
   assign rsp.total_open = otot_ff;
   assign rsp.prizes_collected = walked_ff ? pcnt_ff : '0;
   assign rsp.cells_entered = walked_ff ? mcnt_ff : '0;

   // neighbor of robot in dir_ff
   logic nb_ok;
   logic [RowW-1:0] nrow;
   logic [ColW-1:0] ncol;
   always_comb begin
      nb_ok = 1'b0;
      nrow = rrow_ff;
      ncol = rcol_ff;
      unique case (dir_ff)
         DirRight: begin
            ncol = rcol_ff + 1'b1;
            nb_ok = (SzW'(rcol_ff) + SzW'(1)) < cols_c;
         end
         DirLeft: begin
            ncol = rcol_ff - 1'b1;
            nb_ok = rcol_ff != '0;
         end
         DirDown: begin
            nrow = rrow_ff + 1'b1;
            nb_ok = (SzW'(rrow_ff) + SzW'(1)) < rows_c;
         end
         DirUp: begin
            nrow = rrow_ff - 1'b1;
            nb_ok = rrow_ff != '0;
         end
         default: nb_ok = 1'b0;
      endcase
   end

   logic [2:0] rcls;
   logic edge_cell;
   assign rcls = map_rdata[2:0];
   assign edge_cell = (prow_ff == '0) || (pcol_ff == '0) ||
                      (SzW'(prow_ff) == rows_c - SzW'(1)) ||
                      (SzW'(pcol_ff) == cols_c - SzW'(1));

   always_comb begin
      state_in = state_ff;
      lrow_in = lrow_ff; lcol_in = lcol_ff;
      rrow_in = rrow_ff; rcol_in = rcol_ff;
      orow_in = orow_ff; ocol_in = ocol_ff;
      srow_in = srow_ff; scol_in = scol_ff;
      prow_in = prow_ff; pcol_in = pcol_ff;
      dir_in = dir_ff; scan_wait_in = scan_wait_ff;
      sp_in = sp_ff;
      border_in = border_ff; oseen_in = oseen_ff; walked_in = walked_ff;
      ptot_in = ptot_ff; otot_in = otot_ff; pcnt_in = pcnt_ff; mcnt_in = mcnt_ff;
      map_we = 1'b0;
      map_waddr = {lrow_ff, lcol_ff};
      map_wdata = {1'b0, classify(req.cell_char)};
      map_raddr = {srow_ff, scol_ff};
      stk_we = 1'b0;
      stk_waddr = sp_ff[AddrW-1:0];
      stk_wdata = dir_ff;
      stk_raddr = sp_ff[AddrW-1:0] - 1'b1;
      unique case (state_ff)
         StLoad: begin
            if (req_fire) begin
               map_we = 1'b1;
               if (SzW'(lcol_ff) + SzW'(1) >= cols_c) begin
                  lcol_in = '0;
                  if (SzW'(lrow_ff) + SzW'(1) >= rows_c) lrow_in = '0;
                  else lrow_in = lrow_ff + 1'b1;
               end else begin
                  lcol_in = lcol_ff + 1'b1;
               end
               if (req.last_cell) begin
                  lrow_in = '0; lcol_in = '0;
                  srow_in = '0; scol_in = '0;
                  border_in = 1'b1; oseen_in = 1'b0;
                  ptot_in = '0; otot_in = '0;
                  scan_wait_in = 1'b0;
                  state_in = StScan;
               end
            end
         end
         StScan: begin
            if (!scan_wait_ff) begin
               prow_in = srow_ff; pcol_in = scol_ff;
               scan_wait_in = 1'b1;
            end else begin
               scan_wait_in = 1'b0;
               if (edge_cell && rcls != ClsWall) border_in = 1'b0;
               if (rcls == ClsPrize) ptot_in = sat_inc(ptot_ff);
               if (rcls == ClsPrize || rcls == ClsSpace) otot_in = sat_inc(otot_ff);
               if (rcls == ClsOrigin) begin
                  oseen_in = 1'b1; orow_in = prow_ff; ocol_in = pcol_ff;
               end
               if (SzW'(scol_ff) + SzW'(1) >= cols_c) begin
                  scol_in = '0;
                  if (SzW'(srow_ff) + SzW'(1) >= rows_c) begin
                     srow_in = '0;
                     state_in = StInit;
                  end else begin
                     srow_in = srow_ff + 1'b1;
                  end
               end else begin
                  scol_in = scol_ff + 1'b1;
               end
            end
         end
         StInit: begin
            walked_in = border_ff && oseen_ff;
            if (border_ff && oseen_ff) begin
               map_we = 1'b1;
               map_waddr = {orow_ff, ocol_ff};
               map_wdata = {1'b1, ClsOrigin};
               rrow_in = orow_ff; rcol_in = ocol_ff;
               sp_in = '0; pcnt_in = '0; mcnt_in = '0;
               dir_in = DirRight;
               state_in = StProbe;
            end else begin
               state_in = StDone;
            end
         end
         StProbe: begin
            map_raddr = {nrow, ncol};
            if (nb_ok) begin
               state_in = StCheck;
            end else if (dir_ff == DirUp) begin
               state_in = StPop;
            end else begin
               dir_in = dir_ff + 1'b1;
            end
         end
         StCheck: begin
            if (!map_rdata[3] && rcls != ClsWall && rcls != ClsBlocked) begin
               map_we = 1'b1;
               map_waddr = {nrow, ncol};
               map_wdata = {1'b1, rcls};
               if (sp_ff < (AddrW+1)'(Depth)) begin
                  stk_we = 1'b1;
                  sp_in = sp_ff + 1'b1;
               end
               if (rcls == ClsPrize) pcnt_in = sat_inc(pcnt_ff);
               mcnt_in = sat_inc(mcnt_ff);
               rrow_in = nrow; rcol_in = ncol;
               dir_in = DirRight;
               state_in = StProbe;
            end else if (dir_ff == DirUp) begin
               state_in = StPop;
            end else begin
               dir_in = dir_ff + 1'b1;
               state_in = StProbe;
            end
         end
         StPop: begin
            if (sp_ff == '0) begin
               state_in = StDone;
            end else begin
               sp_in = sp_ff - 1'b1;
               state_in = StBack;
            end
         end
         StBack: begin
            unique case (stk_rdata)
               DirRight: rcol_in = rcol_ff - 1'b1;
               DirLeft:  rcol_in = rcol_ff + 1'b1;
               DirDown:  rrow_in = rrow_ff - 1'b1;
               DirUp:    rrow_in = rrow_ff + 1'b1;
               default:  rrow_in = rrow_ff;
            endcase
            dir_in = DirRight;
            state_in = StProbe;
         end
         StDone: begin
            if (rsp_fire) state_in = StLoad;
         end
         default: state_in = StLoad;
      endcase
      if (state_ff == StBack) stk_raddr = sp_ff[AddrW-1:0];
      if (state_ff == StPop) stk_raddr = sp_ff[AddrW-1:0] - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         rows_ff <= 7'd64; cols_ff <= 7'd64;
         lrow_ff <= '0; lcol_ff <= '0; rrow_ff <= '0; rcol_ff <= '0;
         orow_ff <= '0; ocol_ff <= '0; sp_ff <= '0;
         border_ff <= 1'b1; oseen_ff <= 1'b0; walked_ff <= 1'b0;
         ptot_ff <= '0; otot_ff <= '0; pcnt_ff <= '0; mcnt_ff <= '0;
         scan_wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_index == RegRows) rows_ff <= csr_wdata;
            else cols_ff <= csr_wdata;
         end
         lrow_ff <= lrow_in; lcol_ff <= lcol_in; rrow_ff <= rrow_in; rcol_ff <= rcol_in;
         orow_ff <= orow_in; ocol_ff <= ocol_in; sp_ff <= sp_in;
         border_ff <= border_in; oseen_ff <= oseen_in; walked_ff <= walked_in;
         ptot_ff <= ptot_in; otot_ff <= otot_in; pcnt_ff <= pcnt_in; mcnt_ff <= mcnt_in;
         scan_wait_ff <= scan_wait_in;
      end
      srow_ff <= srow_in; scol_ff <= scol_in;
      prow_ff <= prow_in; pcol_ff <= pcol_in;
      dir_ff <= dir_in;
   end

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StLoad) |-> !req.ready) else $error("ready while busy");
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= (AddrW+1)'(Depth)) else $error("stack overflow");
   a_walk_counts: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= mcnt_ff) else $error("prizes exceed moves");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
endmodule
`default_nettype wire

[rtl/gmde_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module gmde_ram #(
   parameter int Width = 4,
   parameter int Depth = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[test/grid_maze_depth_first_explorer_unit_tb.sv]
// Testbench for the maze explorer: map streams, size settings, walk totals.
module grid_maze_depth_first_explorer_unit_tb;
   import gmde_pkg::*;

   typedef struct packed {
      logic        border_ok;
      logic        origin_found;
      logic [12:0] total_prizes;
      logic [12:0] total_open;
      logic [12:0] prizes_collected;
      logic [12:0] cells_entered;
   } totals_type;

   typedef struct packed {
      logic       is_csr;
      logic       reg_idx;
      logic [7:0] data;
      logic       last;
      logic       typed;
      totals_type want;
   } step_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   logic       csr_index;
   logic [6:0] csr_wdata;

   gmde_req_if req ();
   gmde_rsp_if rsp ();

   grid_maze_depth_first_explorer_unit dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [2:0] cell_cls [4096];
   bit         cell_vis [4096];
   bit         cell_written [4096];
   int         load_r, load_c;
   logic [6:0] rows_reg, cols_reg;
   totals_type totals_q [$];
   int         errors, items, maps, results;
   int         gap_pct, stall_pct;

   step_type directed [] = '{
      '{1'b1, RegRows, 8'd3, 1'b0, 1'b0, '0},
      '{1'b1, RegCols, 8'd3, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, "x", 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, "x", 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, "x", 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, "x", 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, "o", 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, "x", 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, "x", 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, "x", 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, "x", 1'b1, 1'b1, '{1'b1, 1'b1, 13'd0, 13'd0, 13'd0, 13'd0}},
      '{1'b1, RegRows, 8'd0, 1'b0, 1'b0, '0},
      '{1'b1, RegCols, 8'd0, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, "p", 1'b1, 1'b1, '{1'b0, 1'b0, 13'd1, 13'd1, 13'd0, 13'd0}},
      '{1'b0, 1'b0, "o", 1'b1, 1'b1, '{1'b0, 1'b1, 13'd0, 13'd0, 13'd0, 13'd0}},
      '{1'b0, 1'b0, 8'hff, 1'b1, 1'b1, '{1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0}},
      '{1'b0, 1'b0, 8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 13'd0, 13'd0, 13'd0, 13'd0}},
      '{1'b0, 1'b0, " ", 1'b1, 1'b1, '{1'b0, 1'b0, 13'd0, 13'd1, 13'd0, 13'd0}}
   };

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("[grid_maze_depth_first_explorer_unit] ERROR");
      $finish;
   end

   function automatic int clamp_dim(logic [6:0] v);
      return (v == 0) ? 1 : (v > 64) ? 64 : int'(v);
   endfunction

   function automatic logic [2:0] class_of(logic [7:0] ch);
      case (ch)
         "x": return ClsWall;
         "b": return ClsBlocked;
         "p": return ClsPrize;
         " ": return ClsSpace;
         "o": return ClsOrigin;
         default: return ClsOther;
      endcase
   endfunction

   function automatic bit passable(int r, int c, int rows, int cols);
      if (r < 0 || c < 0 || r >= rows || c >= cols) return 0;
      return cell_cls[r*64+c] != ClsWall && cell_cls[r*64+c] != ClsBlocked;
   endfunction

   // Store one cell; on the last cell scan the map and walk it.
   function automatic bit explore_cell(logic [7:0] ch, logic last, output totals_type t);
      int rows, cols, r, c, d, nr, nc, rr, rc, orr, orc, sp;
      bit moved, edge_cell;
      int dstk [4096];
      rows = clamp_dim(rows_reg);
      cols = clamp_dim(cols_reg);
      cell_cls[load_r*64+load_c] = class_of(ch);
      cell_vis[load_r*64+load_c] = 0;
      cell_written[load_r*64+load_c] = 1;
      load_c++;
      if (load_c >= cols) begin
         load_c = 0;
         load_r++;
         if (load_r >= rows) load_r = 0;
      end
      t = '0;
      if (!last) return 0;
      load_r = 0;
      load_c = 0;
      t.border_ok = 1;
      orr = 0;
      orc = 0;
      for (r = 0; r < rows; r++) begin
         for (c = 0; c < cols; c++) begin
            edge_cell = (r == 0 || c == 0 || r == rows-1 || c == cols-1);
            if (edge_cell && cell_cls[r*64+c] != ClsWall) t.border_ok = 0;
            if (cell_cls[r*64+c] == ClsPrize) t.total_prizes++;
            if (cell_cls[r*64+c] == ClsPrize || cell_cls[r*64+c] == ClsSpace)
               t.total_open++;
            if (cell_cls[r*64+c] == ClsOrigin) begin
               t.origin_found = 1;
               orr = r;
               orc = c;
            end
         end
      end
      if (!(t.border_ok && t.origin_found)) return 1;
      rr = orr;
      rc = orc;
      cell_vis[rr*64+rc] = 1;
      sp = 0;
      while (1) begin
         moved = 0;
         for (d = 0; d < 4; d++) begin
            if (!moved) begin
               nr = rr + ((d == 2) ? 1 : (d == 3) ? -1 : 0);
               nc = rc + ((d == 0) ? 1 : (d == 1) ? -1 : 0);
               if (passable(nr, nc, rows, cols) && !cell_vis[nr*64+nc]) begin
                  dstk[sp] = d;
                  sp++;
                  if (cell_cls[nr*64+nc] == ClsPrize) t.prizes_collected++;
                  cell_vis[nr*64+nc] = 1;
                  rr = nr;
                  rc = nc;
                  t.cells_entered++;
                  moved = 1;
               end
            end
         end
         if (!moved) begin
            if (sp == 0) break;
            sp--;
            d = dstk[sp];
            rr = rr - ((d == 2) ? 1 : (d == 3) ? -1 : 0);
            rc = rc - ((d == 0) ? 1 : (d == 1) ? -1 : 0);
         end
      end
      return 1;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch on result %0d: %s got %0d want %0d", results, what, got, want);
   endtask

   task automatic send_cell(logic [7:0] ch, logic last, bit typed, totals_type want);
      totals_type t;
      while ($urandom_range(0, 99) < gap_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.cell_char <= ch;
      req.last_cell <= last;
      do @(posedge clock); while (!req.ready);
      items++;
      if (explore_cell(ch, last, t)) begin
         totals_q.push_back(typed ? want : t);
         maps++;
      end
   endtask

   task automatic write_csr(logic idx, logic [6:0] val);
      req.valid <= 1'b0;
      while (totals_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == RegRows) rows_reg = val;
      else cols_reg = val;
   endtask

   function automatic logic [7:0] pick_inner();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return " ";
      if (p < 55) return "p";
      if (p < 70) return "b";
      if (p < 80) return "x";
      if (p < 85) return "o";
      return 8'($urandom_range(0, 255));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
         if (rsp.valid && rsp.ready) begin
            results++;
            if (totals_q.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               if (rsp.border_ok !== totals_q[0].border_ok)
                  report_mismatch("border_ok", rsp.border_ok, totals_q[0].border_ok);
               if (rsp.origin_found !== totals_q[0].origin_found)
                  report_mismatch("origin_found", rsp.origin_found, totals_q[0].origin_found);
               if (rsp.total_prizes !== totals_q[0].total_prizes)
                  report_mismatch("total_prizes", rsp.total_prizes, totals_q[0].total_prizes);
               if (rsp.total_open !== totals_q[0].total_open)
                  report_mismatch("total_open", rsp.total_open, totals_q[0].total_open);
               if (rsp.prizes_collected !== totals_q[0].prizes_collected)
                  report_mismatch("prizes_collected", rsp.prizes_collected,
                                  totals_q[0].prizes_collected);
               if (rsp.cells_entered !== totals_q[0].cells_entered)
                  report_mismatch("cells_entered", rsp.cells_entered,
                                  totals_q[0].cells_entered);
               void'(totals_q.pop_front());
            end
         end
      end
   end

   initial begin
      int i, k, n, area, rows, cols, orr, orc, kind, phase;
      bit covered;
      logic [6:0] rv, cv;
      logic [7:0] ch;
      logic [7:0] cells [$];
      req.valid <= 1'b0;
      req.cell_char <= 8'h00;
      req.last_cell <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= 1'b0;
      csr_wdata <= 7'd0;
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      load_r = 0;
      load_c = 0;
      errors = 0;
      items = 0;
      maps = 0;
      results = 0;
      gap_pct = 0;
      stall_pct = 0;
      for (i = 0; i < 4096; i++) begin
         cell_cls[i] = ClsOther;
         cell_vis[i] = 0;
         cell_written[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_csr)
            write_csr(directed[i].reg_idx, directed[i].data[6:0]);
         else
            send_cell(directed[i].data, directed[i].last, directed[i].typed,
                      directed[i].want);
      end

      while (items < 1950) begin
         phase = (items / 240) % 4;
         gap_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 24 : 48) : 0;
         stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 24 : 48) : 0;
         k = $urandom_range(0, 99);
         if (k < 6) begin
            rv = 7'd64; cv = 7'($urandom_range(3, 4));
         end else if (k < 12) begin
            rv = 7'($urandom_range(3, 4)); cv = 7'd64;
         end else if (k < 16) begin
            rv = 7'($urandom_range(65, 127)); cv = 7'($urandom_range(0, 3));
         end else if (k < 20) begin
            rv = 7'($urandom_range(0, 2)); cv = 7'($urandom_range(0, 8));
         end else begin
            rv = 7'($urandom_range(3, 9)); cv = 7'($urandom_range(3, 9));
         end
         if (rv != rows_reg) write_csr(RegRows, rv);
         if (cv != cols_reg) write_csr(RegCols, cv);
         rows = clamp_dim(rows_reg);
         cols = clamp_dim(cols_reg);
         area = rows * cols;
         orr = $urandom_range(0, rows - 1);
         orc = $urandom_range(0, cols - 1);
         kind = $urandom_range(0, 99);
         cells.delete();
         for (i = 0; i < area; i++) begin
            if (kind < 75) begin
               if (i / cols == 0 || i % cols == 0 || i / cols == rows - 1 ||
                   i % cols == cols - 1)
                  ch = ($urandom_range(0, 49) == 0) ? pick_inner() : "x";
               else if (i == orr * cols + orc)
                  ch = "o";
               else
                  ch = pick_inner();
            end else begin
               ch = ($urandom_range(0, 1)) ? pick_inner() : 8'($urandom_range(0, 255));
            end
            cells.push_back(ch);
         end
         if (kind >= 88 && kind < 94) begin
            n = $urandom_range(1, cols + 2);
            for (i = 0; i < n; i++) cells.push_back(pick_inner());
         end else if (kind >= 94 && area > 1) begin
            covered = 1;
            for (i = 0; i < area; i++)
               if (!cell_written[(i / cols) * 64 + i % cols]) covered = 0;
            if (covered) begin
               n = $urandom_range(1, area - 1);
               while (cells.size() > n) void'(cells.pop_back());
            end
         end
         foreach (cells[i]) send_cell(cells[i], i == cells.size() - 1, 1'b0, '0);
      end
      req.valid <= 1'b0;

      while (totals_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d maps from %0d map cells, %0d totals checked, %0d mismatches",
               maps, items, results, errors);
      if (errors == 0)
         $display("[grid_maze_depth_first_explorer_unit] OK");
      else
         $display("[grid_maze_depth_first_explorer_unit] ERROR");
      $finish;
   end
endmodule
